>>> rtl/xbr_pkg.sv
`default_nettype none
package xbr_pkg;

   localparam int unsigned AddrWidth  = 64;
   localparam int unsigned DispWidth  = 32;
   localparam int unsigned MaxBytes   = 12;
   localparam int unsigned BufWidth   = 8 * MaxBytes;

   localparam logic [3:0] LEN_NONE  = 4'd0;
   localparam logic [3:0] LEN_REL8  = 4'd2;
   localparam logic [3:0] LEN_REL32 = 4'd5;
   localparam logic [3:0] LEN_ABS   = 4'd12;

   localparam logic [7:0] OP_REX_W     = 8'h48;
   localparam logic [7:0] OP_MOV_RAX   = 8'hB8;
   localparam logic [7:0] OP_GRP5      = 8'hFF;
   localparam logic [7:0] MODRM_JMP_AX = 8'hE0;
   localparam logic [7:0] MODRM_CALL_AX = 8'hD0;
   localparam logic [7:0] OP_JMP_REL32 = 8'hE9;
   localparam logic [7:0] OP_CALL_REL32 = 8'hE8;
   localparam logic [7:0] OP_JMP_REL8  = 8'hEB;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_NULL       = 3'd1,
      STATUS_TOO_FAR    = 3'd2,
      STATUS_NO_SPACE   = 3'd3,
      STATUS_SHORT_CALL = 3'd4
   } status_type;

   // Request after the offset stage, handed to the byte emitter.
   typedef struct packed {
      logic [AddrWidth-1:0] abs_addr;
      logic [AddrWidth-1:0] offset;
      logic                 is_null;
      logic                 is_call;
      logic                 size_only;
      logic [7:0]           buffer_space;
   } xbr_s3_type;

endpackage
`default_nettype wire

>>> rtl/xbr_emit.sv
`default_nettype none
module xbr_emit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               long_mode,
   input  wire logic               in_valid,
   output logic                    in_stall,
   input  wire xbr_pkg::xbr_s3_type in_req,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_byte_valid,
   output logic                    rsp_last,
   output logic [2:0]              rsp_status,
   output logic [3:0]              rsp_encoded_length
);
   import xbr_pkg::*;

   logic [BufWidth-1:0]  buf_ff, buf_in;
   logic [3:0]           remain_ff, remain_in;
   logic                 bvalid_ff, bvalid_in;
   status_type           status_ff, status_in;
   logic [3:0]           len_ff, len_in;
   logic                 valid_ff, valid_in;

   logic [AddrWidth-1:0] off8;
   logic [AddrWidth-1:0] off32;
   logic                 far;
   logic                 fits8;
   logic [3:0]           need_len;
   logic                 accept_out;
   logic                 is_last;
   logic                 load;

   assign is_last    = (remain_ff == 4'd1);
   assign accept_out = valid_ff && !rsp_stall;
   assign load       = in_valid && (!valid_ff || (accept_out && is_last));
   assign in_stall   = valid_ff && !(accept_out && is_last);

   // Offsets measured from the end of the new instruction.
   assign off8  = in_req.offset - AddrWidth'(2);
   assign off32 = in_req.offset - AddrWidth'(5);
   assign far   = !((&off32[AddrWidth-1:31]) || !(|off32[AddrWidth-1:31]));
   assign fits8 = (&off8[AddrWidth-1:7]) || !(|off8[AddrWidth-1:7]);

   always_comb begin
      if (far) begin
         need_len = LEN_ABS;
      end else if (!fits8) begin
         need_len = LEN_REL32;
      end else begin
         need_len = LEN_REL8;
      end
   end

   always_comb begin
      buf_in    = buf_ff;
      remain_in = remain_ff;
      bvalid_in = bvalid_ff;
      status_in = status_ff;
      len_in    = len_ff;
      valid_in  = valid_ff;
      if (load) begin
         valid_in  = 1'b1;
         buf_in    = '0;
         remain_in = 4'd1;
         bvalid_in = 1'b0;
         len_in    = need_len;
         status_in = STATUS_OK;
         if (in_req.is_null) begin
            status_in = STATUS_NULL;
            len_in    = LEN_NONE;
         end else if (far && !long_mode) begin
            status_in = STATUS_TOO_FAR;
            len_in    = LEN_NONE;
         end else if (in_req.size_only) begin
            status_in = STATUS_OK;
         end else if ({4'd0, need_len} > in_req.buffer_space) begin
            status_in = STATUS_NO_SPACE;
         end else if (need_len == LEN_REL8 && in_req.is_call) begin
            status_in = STATUS_SHORT_CALL;
         end else begin
            bvalid_in = 1'b1;
            remain_in = need_len;
            if (need_len == LEN_ABS) begin
               buf_in = {in_req.is_call ? MODRM_CALL_AX : MODRM_JMP_AX, OP_GRP5,
                         in_req.abs_addr, OP_MOV_RAX, OP_REX_W};
            end else if (need_len == LEN_REL32) begin
               buf_in = {56'd0, off32[31:0],
                         in_req.is_call ? OP_CALL_REL32 : OP_JMP_REL32};
            end else begin
               buf_in = {80'd0, off8[7:0], OP_JMP_REL8};
            end
         end
      end else if (accept_out) begin
         if (is_last) begin
            valid_in = 1'b0;
         end else begin
            // advance to the next byte of this request
            buf_in    = {8'd0, buf_ff[BufWidth-1:8]};
            remain_in = remain_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      buf_ff    <= buf_in;
      remain_ff <= remain_in;
      bvalid_ff <= bvalid_in;
      status_ff <= status_in;
      len_ff    <= len_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_out_byte       = buf_ff[7:0];
   assign rsp_byte_valid     = bvalid_ff;
   assign rsp_last           = is_last;
   assign rsp_status         = status_ff;
   assign rsp_encoded_length = len_ff;

endmodule
`default_nettype wire

>>> rtl/x86_branch_relocator.sv
`default_nettype none
// Relocates one decoded relative jmp or call per request. A request passes an
// input register, a target adder and an offset subtractor, then the byte
// emitter, which registers its results. Requests enter every cycle unless
// req_stall holds them; a request that ends in a status or a size report gives
// a single result, while an emitted encoding gives 2, 5 or 12 byte results,
// one per cycle from the emitter's output register while rsp_stall is low, and
// holds the pipeline behind it until its last byte is taken. csr_write_data
// sets long mode (reset 1), which enables the 12-byte absolute form.
module x86_branch_relocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_source_address,
   input  wire logic [63:0] req_target_address,
   input  wire logic [3:0]  req_insn_length,
   input  wire logic signed [31:0] req_branch_displacement,
   input  wire logic        req_is_call,
   input  wire logic        req_size_only,
   input  wire logic [7:0]  req_buffer_space,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_last,
   output logic [2:0]       rsp_status,
   output logic [3:0]       rsp_encoded_length
);
   import xbr_pkg::*;

   logic                 long_mode_ff;

   logic                 s1_valid_ff;
   logic [AddrWidth-1:0] s1_src_ff;
   logic [AddrWidth-1:0] s1_dst_ff;
   logic [3:0]           s1_ilen_ff;
   logic [DispWidth-1:0] s1_disp_ff;
   logic                 s1_call_ff;
   logic                 s1_size_ff;
   logic [7:0]           s1_space_ff;

   logic                 s2_valid_ff;
   logic [AddrWidth-1:0] s2_abs_ff, s2_abs_in;
   logic [AddrWidth-1:0] s2_dst_ff;
   logic                 s2_call_ff;
   logic                 s2_size_ff;
   logic [7:0]           s2_space_ff;

   logic                 s3_valid_ff;
   xbr_s3_type           s3_ff, s3_in;

   logic                 emit_stall;
   logic                 s3_open;
   logic                 s2_open;
   logic                 s1_open;

   // A stage takes new data when empty or when its content moves on.
   assign s3_open   = !s3_valid_ff || !emit_stall;
   assign s2_open   = !s2_valid_ff || s3_open;
   assign s1_open   = !s1_valid_ff || s2_open;
   assign req_stall = !s1_open;

   assign s2_abs_in = s1_src_ff
                    + {{(AddrWidth-DispWidth){s1_disp_ff[DispWidth-1]}}, s1_disp_ff}
                    + {{(AddrWidth-4){1'b0}}, s1_ilen_ff};

   always_comb begin
      s3_in.abs_addr     = s2_abs_ff;
      s3_in.offset       = s2_abs_ff - s2_dst_ff;
      s3_in.is_null      = (s2_abs_ff == '0);
      s3_in.is_call      = s2_call_ff;
      s3_in.size_only    = s2_size_ff;
      s3_in.buffer_space = s2_space_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_mode_ff <= 1'b1;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            long_mode_ff <= csr_write_data;
         end
         if (s1_open) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_open) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_open) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_open) begin
         s1_src_ff   <= req_source_address;
         s1_dst_ff   <= req_target_address;
         s1_ilen_ff  <= req_insn_length;
         s1_disp_ff  <= req_branch_displacement;
         s1_call_ff  <= req_is_call;
         s1_size_ff  <= req_size_only;
         s1_space_ff <= req_buffer_space;
      end
      if (s2_open) begin
         s2_abs_ff   <= s2_abs_in;
         s2_dst_ff   <= s1_dst_ff;
         s2_call_ff  <= s1_call_ff;
         s2_size_ff  <= s1_size_ff;
         s2_space_ff <= s1_space_ff;
      end
      if (s3_open) begin
         s3_ff <= s3_in;
      end
   end

   xbr_emit u_emit (
      .clock              (clock),
      .reset              (reset),
      .long_mode          (long_mode_ff),
      .in_valid           (s3_valid_ff),
      .in_stall           (emit_stall),
      .in_req             (s3_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_last           (rsp_last),
      .rsp_status         (rsp_status),
      .rsp_encoded_length (rsp_encoded_length)
   );

endmodule
`default_nettype wire

>>> rtl/xbr_checker.sv
`default_nettype none
module xbr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_byte_valid,
   input wire logic       rsp_last,
   input wire logic [2:0] rsp_status,
   input wire logic [3:0] rsp_encoded_length
);
   import xbr_pkg::*;

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_last) && $stable(rsp_status) && $stable(rsp_encoded_length))
      else $error("stalled response changed");

   // A result without a byte is a request's only result and carries zero.
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last && rsp_out_byte == 8'd0)
      else $error("byte-less response not single");

   // Emitted bytes come only with good status and a real encoding length.
   a_bytes_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> rsp_status == STATUS_OK
         && (rsp_encoded_length == LEN_REL8 || rsp_encoded_length == LEN_REL32
             || rsp_encoded_length == LEN_ABS))
      else $error("byte with bad status or length");

   // A taken byte that is not last is followed at once by the next byte.
   a_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_byte_valid && !rsp_last
         |=> rsp_valid && rsp_byte_valid && $stable(rsp_encoded_length))
      else $error("byte run broken");

endmodule

bind x86_branch_relocator xbr_checker u_xbr_checker (.*);
`default_nettype wire
